// ===== rtl/core/ubfc_pkg.sv =====
// shared constants, codes and types of the buffered serial-line manager
package ubfc_pkg;

   localparam int BUFFER_DEPTH       = 512;
   localparam int READER_QUEUE_DEPTH = 512;
   localparam int FLUSH_QUEUE_DEPTH  = 1;
   localparam int MAX_RESULTS        = 3;

   localparam int BYTE_W = 8;
   localparam int ID_W   = 8;

   localparam int BUF_IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int BUF_CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int RDQ_IDX_W = (READER_QUEUE_DEPTH > 1) ? $clog2(READER_QUEUE_DEPTH) : 1;
   localparam int RDQ_CNT_W = $clog2(READER_QUEUE_DEPTH + 1);
   localparam int FLQ_IDX_W = (FLUSH_QUEUE_DEPTH > 1) ? $clog2(FLUSH_QUEUE_DEPTH) : 1;
   localparam int FLQ_CNT_W = $clog2(FLUSH_QUEUE_DEPTH + 1);
   localparam int RES_W     = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_LINE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_REPLY   = 2'd0,
      KIND_TX      = 2'd1,
      KIND_OVERRUN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TX_FULL  = 2'd1,
      ST_RDQ_FULL = 2'd2,
      ST_FLQ_FULL = 2'd3
   } status_type;

   // where a result takes its target from
   typedef enum logic [1:0] {
      TSEL_ZERO = 2'd0,
      TSEL_REQ  = 2'd1,
      TSEL_RDQ  = 2'd2,
      TSEL_FLQ  = 2'd3
   } tsel_type;

   // where a result takes its value from
   typedef enum logic [1:0] {
      VSEL_ZERO = 2'd0,
      VSEL_DATA = 2'd1,
      VSEL_RXQ  = 2'd2,
      VSEL_TXQ  = 2'd3
   } vsel_type;

   typedef struct packed {
      kind_type   kind;
      tsel_type   tsel;
      vsel_type   vsel;
      status_type status;
   } desc_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   target;
      logic [BYTE_W-1:0] value;
      status_type        status;
      logic              last;
   } result_type;

   typedef struct packed {
      logic             capture;
      logic             exec;
      logic             load;
      logic [RES_W-1:0] idx;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic [RES_W-1:0] total;
   } sts_type;

endpackage

// ===== rtl/core/ubfc_ifs.sv =====
// channel interfaces: request, response and control register write
interface ubfc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] requester;
   logic [7:0] data_byte;
   logic       rx_ready;
   logic       tx_ready;
   logic       modem_change;
   logic       cts_level;

   modport source (output valid, opcode, requester, data_byte, rx_ready, tx_ready,
                   modem_change, cts_level, input ready);
   modport sink   (input valid, opcode, requester, data_byte, rx_ready, tx_ready,
                   modem_change, cts_level, output ready);
endinterface

interface ubfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] target;
   logic [7:0] value;
   logic [1:0] status;
   logic       last;

   modport source (output valid, kind, target, value, status, last, input ready);
   modport sink   (input valid, kind, target, value, status, last, output ready);
endinterface

interface ubfc_csr_if;
   logic valid;
   logic ready;
   logic cts_always;

   modport source (output valid, cts_always, input ready);
   modport sink   (input valid, cts_always, output ready);
endinterface

// ===== rtl/core/ubfc_datapath.sv =====
// datapath: fifos, queues, line flags, result descriptors and response register
module ubfc_datapath
   import ubfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [1:0]        in_opcode,
   input  logic [ID_W-1:0]   in_requester,
   input  logic [BYTE_W-1:0] in_data_byte,
   input  logic              in_rx_ready,
   input  logic              in_tx_ready,
   input  logic              in_modem_change,
   input  logic              in_cts_level,
   input  logic              csr_we,
   input  logic              csr_data,
   output result_type        result
);

   // captured item
   op_type            op_ff;
   logic [ID_W-1:0]   req_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              rxr_ff, txr_ff, mc_ff, ctsl_ff;

   logic cts_always_ff, txe_ff, cts_ff;
   logic txe_in, cts_in;

   logic [BYTE_W-1:0] rx_mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0] tx_mem [BUFFER_DEPTH];
   logic [ID_W-1:0]   rdq_mem [READER_QUEUE_DEPTH];
   logic [ID_W-1:0]   flq_ff [FLUSH_QUEUE_DEPTH];
   logic [BYTE_W-1:0] rx_rd_ff, tx_rd_ff;
   logic [ID_W-1:0]   rdq_rd_ff;

   logic [BUF_IDX_W-1:0] rx_head_ff, rx_tail_ff, tx_head_ff, tx_tail_ff;
   logic [BUF_CNT_W-1:0] rx_cnt_ff, tx_cnt_ff;
   logic [RDQ_IDX_W-1:0] rdq_head_ff, rdq_tail_ff;
   logic [RDQ_CNT_W-1:0] rdq_cnt_ff;
   logic [FLQ_IDX_W-1:0] flq_head_ff, flq_tail_ff;
   logic [FLQ_CNT_W-1:0] flq_cnt_ff;

   logic rx_push, rx_pop, tx_push, tx_pop, rdq_push, rdq_pop, flq_push, flq_pop;

   desc_type         desc_ff [2];
   desc_type         desc_in [2];
   logic [RES_W-1:0] npre_ff, npre_in;
   result_type       result_ff, result_in;

   logic [BUF_CNT_W-1:0] tx_cnt_in;
   logic [FLQ_CNT_W-1:0] flq_cnt_mid;
   logic [RES_W-1:0]     rel;

   // execute: decide pushes, pops and the results that precede flush releases
   always_comb begin
      logic [RES_W-1:0]         n;
      logic                     send;
      desc_type                 reply;
      logic [FLQ_CNT_W+RES_W:0] cap_x, cnt_x;

      n        = '0;
      send     = 1'b0;
      reply    = '{KIND_REPLY, TSEL_REQ, VSEL_ZERO, ST_OK};
      rx_push  = 1'b0;
      rx_pop   = 1'b0;
      tx_push  = 1'b0;
      tx_pop   = 1'b0;
      rdq_push = 1'b0;
      rdq_pop  = 1'b0;
      flq_push = 1'b0;
      txe_in   = txe_ff;
      cts_in   = cts_ff;
      desc_in[0] = '{KIND_REPLY, TSEL_ZERO, VSEL_ZERO, ST_OK};
      desc_in[1] = '{KIND_REPLY, TSEL_ZERO, VSEL_ZERO, ST_OK};

      unique case (op_ff)
         OP_PUT: begin
            if (tx_cnt_ff == BUF_CNT_W'(BUFFER_DEPTH)) begin
               reply.status = ST_TX_FULL;
            end else begin
               tx_push = 1'b1;
            end
            send = txe_ff && (cts_ff || cts_always_ff) && (tx_cnt_ff != '0 || tx_push);
            if (send) begin
               // empty fifo: the byte just pushed is the one sent
               desc_in[0] = '{KIND_TX, TSEL_ZERO,
                              (tx_cnt_ff == '0) ? VSEL_DATA : VSEL_TXQ, ST_OK};
               desc_in[1] = reply;
               n = RES_W'(2);
            end else begin
               desc_in[0] = reply;
               n = RES_W'(1);
            end
         end
         OP_GET: begin
            if (rx_cnt_ff != '0) begin
               rx_pop     = 1'b1;
               desc_in[0] = '{KIND_REPLY, TSEL_REQ, VSEL_RXQ, ST_OK};
               n          = RES_W'(1);
            end else if (rdq_cnt_ff == RDQ_CNT_W'(READER_QUEUE_DEPTH)) begin
               desc_in[0] = '{KIND_REPLY, TSEL_REQ, VSEL_ZERO, ST_RDQ_FULL};
               n          = RES_W'(1);
            end else begin
               rdq_push = 1'b1;
            end
         end
         OP_FLUSH: begin
            if (tx_cnt_ff == '0) begin
               desc_in[0] = '{KIND_REPLY, TSEL_REQ, VSEL_ZERO, ST_OK};
               n          = RES_W'(1);
            end else if (flq_cnt_ff == FLQ_CNT_W'(FLUSH_QUEUE_DEPTH)) begin
               desc_in[0] = '{KIND_REPLY, TSEL_REQ, VSEL_ZERO, ST_FLQ_FULL};
               n          = RES_W'(1);
            end else begin
               flq_push = 1'b1;
            end
         end
         OP_LINE: begin
            if (rxr_ff) begin
               if (rdq_cnt_ff != '0) begin
                  rdq_pop    = 1'b1;
                  desc_in[0] = '{KIND_REPLY, TSEL_RDQ, VSEL_DATA, ST_OK};
                  n          = RES_W'(1);
               end else if (rx_cnt_ff == BUF_CNT_W'(BUFFER_DEPTH)) begin
                  desc_in[0] = '{KIND_OVERRUN, TSEL_ZERO, VSEL_ZERO, ST_OK};
                  n          = RES_W'(1);
               end else begin
                  rx_push = 1'b1;
               end
            end
            if (txr_ff) begin
               txe_in = 1'b1;
            end
            if (mc_ff) begin
               cts_in = ctsl_ff;
            end
            send = txe_in && (cts_in || cts_always_ff) && (tx_cnt_ff != '0);
            if (send) begin
               desc_in[n[0]] = '{KIND_TX, TSEL_ZERO, VSEL_TXQ, ST_OK};
               n = n + 1'b1;
            end
         end
         default: ;
      endcase

      if (send) begin
         tx_pop = 1'b1;
         txe_in = 1'b0;
         if (!cts_always_ff) begin
            cts_in = 1'b0;
         end
      end

      tx_cnt_in   = tx_cnt_ff + BUF_CNT_W'(tx_push) - BUF_CNT_W'(tx_pop);
      flq_cnt_mid = flq_cnt_ff + FLQ_CNT_W'(flq_push);

      // flush waiters go out once the transmit fifo is empty, as many as fit
      cap_x = (FLQ_CNT_W + RES_W + 1)'(RES_W'(MAX_RESULTS) - n);
      cnt_x = (FLQ_CNT_W + RES_W + 1)'(flq_cnt_mid);
      if (tx_cnt_in != '0) begin
         rel = '0;
      end else if (cnt_x >= cap_x) begin
         rel = RES_W'(cap_x);
      end else begin
         rel = RES_W'(cnt_x);
      end
      npre_in   = n;
      sts.total = n + rel;
   end

   // response selection and flush waiter pop
   always_comb begin
      desc_type d;
      logic     from_desc;

      from_desc = (cmd.idx < npre_ff);
      d         = desc_ff[cmd.idx[0]];
      if (!from_desc) begin
         d = '{KIND_REPLY, TSEL_FLQ, VSEL_ZERO, ST_OK};
      end
      flq_pop = cmd.load && !from_desc;

      result_in.kind   = d.kind;
      result_in.status = d.status;
      result_in.last   = cmd.last;
      case (d.tsel)
         TSEL_REQ: result_in.target = req_ff;
         TSEL_RDQ: result_in.target = rdq_rd_ff;
         TSEL_FLQ: result_in.target = flq_ff[flq_head_ff];
         default:  result_in.target = '0;
      endcase
      case (d.vsel)
         VSEL_DATA: result_in.value = data_ff;
         VSEL_RXQ:  result_in.value = rx_rd_ff;
         VSEL_TXQ:  result_in.value = tx_rd_ff;
         default:   result_in.value = '0;
      endcase
   end

   assign result = result_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(in_opcode);
         req_ff  <= in_requester;
         data_ff <= in_data_byte;
         rxr_ff  <= in_rx_ready;
         txr_ff  <= in_tx_ready;
         mc_ff   <= in_modem_change;
         ctsl_ff <= in_cts_level;
      end
      if (cmd.exec) begin
         desc_ff[0] <= desc_in[0];
         desc_ff[1] <= desc_in[1];
         npre_ff    <= npre_in;
      end
      if (cmd.load) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cts_always_ff <= 1'b0;
         txe_ff        <= 1'b1;
         cts_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            cts_always_ff <= csr_data;
         end
         if (cmd.exec) begin
            txe_ff <= txe_in;
            cts_ff <= cts_in;
         end
      end
   end

   // memories: one write and one registered read each; the flush queue is read directly
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rx_rd_ff  <= rx_mem[rx_head_ff];
         tx_rd_ff  <= tx_mem[tx_head_ff];
         rdq_rd_ff <= rdq_mem[rdq_head_ff];
         if (rx_push) begin
            rx_mem[rx_tail_ff] <= data_ff;
         end
         if (tx_push) begin
            tx_mem[tx_tail_ff] <= data_ff;
         end
         if (rdq_push) begin
            rdq_mem[rdq_tail_ff] <= req_ff;
         end
         if (flq_push) begin
            flq_ff[flq_tail_ff] <= req_ff;
         end
      end
   end

   // ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         rx_cnt_ff   <= '0;
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
         tx_cnt_ff   <= '0;
         rdq_head_ff <= '0;
         rdq_tail_ff <= '0;
         rdq_cnt_ff  <= '0;
         flq_head_ff <= '0;
         flq_tail_ff <= '0;
         flq_cnt_ff  <= '0;
      end else begin
         if (cmd.exec) begin
            if (rx_push) begin
               rx_tail_ff <= (rx_tail_ff == BUF_IDX_W'(BUFFER_DEPTH - 1)) ? '0
                             : rx_tail_ff + 1'b1;
            end
            if (rx_pop) begin
               rx_head_ff <= (rx_head_ff == BUF_IDX_W'(BUFFER_DEPTH - 1)) ? '0
                             : rx_head_ff + 1'b1;
            end
            rx_cnt_ff <= rx_cnt_ff + BUF_CNT_W'(rx_push) - BUF_CNT_W'(rx_pop);
            if (tx_push) begin
               tx_tail_ff <= (tx_tail_ff == BUF_IDX_W'(BUFFER_DEPTH - 1)) ? '0
                             : tx_tail_ff + 1'b1;
            end
            if (tx_pop) begin
               tx_head_ff <= (tx_head_ff == BUF_IDX_W'(BUFFER_DEPTH - 1)) ? '0
                             : tx_head_ff + 1'b1;
            end
            tx_cnt_ff <= tx_cnt_in;
            if (rdq_push) begin
               rdq_tail_ff <= (rdq_tail_ff == RDQ_IDX_W'(READER_QUEUE_DEPTH - 1)) ? '0
                              : rdq_tail_ff + 1'b1;
            end
            if (rdq_pop) begin
               rdq_head_ff <= (rdq_head_ff == RDQ_IDX_W'(READER_QUEUE_DEPTH - 1)) ? '0
                              : rdq_head_ff + 1'b1;
            end
            rdq_cnt_ff <= rdq_cnt_ff + RDQ_CNT_W'(rdq_push) - RDQ_CNT_W'(rdq_pop);
            if (flq_push) begin
               flq_tail_ff <= (flq_tail_ff == FLQ_IDX_W'(FLUSH_QUEUE_DEPTH - 1)) ? '0
                              : flq_tail_ff + 1'b1;
               flq_cnt_ff  <= flq_cnt_mid;
            end
         end
         if (flq_pop) begin
            flq_head_ff <= (flq_head_ff == FLQ_IDX_W'(FLUSH_QUEUE_DEPTH - 1)) ? '0
                           : flq_head_ff + 1'b1;
            flq_cnt_ff  <= flq_cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/ubfc_ctrl.sv =====
// controller: accept, execute and result emission sequencing
module ubfc_ctrl
   import ubfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [RES_W-1:0] idx_ff, idx_in;
   logic [RES_W-1:0] total_ff, total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.load    = (state_ff == S_EMIT) && out_free;
      cmd.idx     = idx_ff;
      cmd.last    = (idx_ff == total_ff - 1'b1);

      state_in = state_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            idx_in   = '0;
            total_in = sts.total;
            state_in = (sts.total == '0) ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               idx_in = idx_ff + 1'b1;
               if (cmd.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/uart_buffer_flow_control.sv =====
// top level of the buffered serial-line manager with flow control
//
//  channel   direction  carries
//  req_if    in         opcode, requester, data_byte, rx_ready, tx_ready,
//                       modem_change, cts_level
//  rsp_if    out        kind, target, value, status, last
//  csr_if    in         cts_always register write
//
// an item passes through the accept edge, an execute step in which the fifo
// memories are read into registers, then each of its results in turn
// through the response register
// a stalled response holds the sequencer in its emit step; the last result
// of an item sits in the response register while the next item is taken
// reset clears pointers, flags and sequencer; fifo data needs no clearing
module uart_buffer_flow_control
   import ubfc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ubfc_req_if.sink   req_if,
   ubfc_rsp_if.source rsp_if,
   ubfc_csr_if.sink   csr_if
);

   cmd_type    cmd;
   sts_type    sts;
   result_type result;

   // register writes are always taken
   assign csr_if.ready = 1'b1;

   ubfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ubfc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .in_opcode       (req_if.opcode),
      .in_requester    (req_if.requester),
      .in_data_byte    (req_if.data_byte),
      .in_rx_ready     (req_if.rx_ready),
      .in_tx_ready     (req_if.tx_ready),
      .in_modem_change (req_if.modem_change),
      .in_cts_level    (req_if.cts_level),
      .csr_we          (csr_if.valid),
      .csr_data        (csr_if.cts_always),
      .result          (result)
   );

   // response payload straight from the output register
   assign rsp_if.kind   = 2'(result.kind);
   assign rsp_if.target = result.target;
   assign rsp_if.value  = result.value;
   assign rsp_if.status = 2'(result.status);
   assign rsp_if.last   = result.last;

endmodule

// ===== verif/tb_uart_buffer_flow_control.sv =====
// self-checking testbench for the buffered serial-line manager with flow control
module tb_uart_buffer_flow_control;
   import ubfc_pkg::*;

   typedef logic [BYTE_W-1:0] byte_t;
   typedef logic [ID_W-1:0]   id_t;

   logic clock;
   logic reset;

   ubfc_req_if req_bus ();
   ubfc_rsp_if rsp_bus ();
   ubfc_csr_if csr_bus ();

   uart_buffer_flow_control uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // predicted line manager state, updated on every accepted transfer
   byte_t rx_bytes[$];             // received bytes nobody asked for yet
   id_t   readers[$];              // blocked get requests, oldest first
   byte_t tx_bytes[$];             // bytes waiting for the transmitter
   id_t   flushers[$];             // flush requests waiting for the drain
   logic  line_tx_empty = 1'b1;    // transmit holding register free
   logic  line_cts      = 1'b0;    // last clear-to-send level seen
   logic  cts_forced    = 1'b0;    // register copy: no clear-to-send wire

   result_type step_results[$];    // results of the transfer being predicted
   result_type awaited[$];         // expected results, oldest first

   int fail_count = 0;
   int shown      = 0;

   // idling control
   bit steady       = 1'b0;        // no gaps on either side while set
   int hold_len     = 0;
   int hold_tickets = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int rsp_gap      = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic byte_t rnd8();
      return byte_t'($urandom_range(0, 255));
   endfunction

   // at most MAX_RESULTS results per transfer, extra ones are lost
   function automatic void add_result(kind_type k, id_t who, byte_t val, status_type st);
      if (step_results.size() < MAX_RESULTS)
         step_results.push_back('{kind: k, target: who, value: val, status: st, last: 1'b0});
   endfunction

   // one byte leaves only with the transmitter free and clear-to-send held or forced
   function automatic void try_transmit();
      if (line_tx_empty && (line_cts || cts_forced) && tx_bytes.size() > 0) begin
         add_result(KIND_TX, '0, tx_bytes.pop_front(), ST_OK);
         line_tx_empty = 1'b0;
         if (!cts_forced)
            line_cts = 1'b0;
      end
   endfunction

   function automatic void predict_results(op_type op, id_t who, byte_t data,
                                           logic rx, logic tx, logic mc, logic cts);
      status_type st;
      step_results.delete();
      case (op)
         OP_PUT: begin
            // a full transmit fifo drops the byte but a send is still tried
            st = ST_OK;
            if (tx_bytes.size() >= BUFFER_DEPTH)
               st = ST_TX_FULL;
            else
               tx_bytes.push_back(data);
            try_transmit();
            add_result(KIND_REPLY, who, '0, st);
         end
         OP_GET: begin
            if (rx_bytes.size() > 0)
               add_result(KIND_REPLY, who, rx_bytes.pop_front(), ST_OK);
            else if (readers.size() >= READER_QUEUE_DEPTH)
               add_result(KIND_REPLY, who, '0, ST_RDQ_FULL);
            else
               readers.push_back(who);
         end
         OP_FLUSH: begin
            if (tx_bytes.size() == 0)
               add_result(KIND_REPLY, who, '0, ST_OK);
            else if (flushers.size() >= FLUSH_QUEUE_DEPTH)
               add_result(KIND_REPLY, who, '0, ST_FLQ_FULL);
            else
               flushers.push_back(who);
         end
         default: begin
            // line event: received byte, then transmitter flag, then cts change
            if (rx) begin
               if (readers.size() > 0)
                  add_result(KIND_REPLY, readers.pop_front(), data, ST_OK);
               else if (rx_bytes.size() >= BUFFER_DEPTH)
                  add_result(KIND_OVERRUN, '0, '0, ST_OK);
               else
                  rx_bytes.push_back(data);
            end
            if (tx)
               line_tx_empty = 1'b1;
            if (mc)
               line_cts = cts;
            try_transmit();
         end
      endcase
      // drained fifo releases flush waiters while result slots remain
      while (tx_bytes.size() == 0 && flushers.size() > 0 && step_results.size() < MAX_RESULTS)
         add_result(KIND_REPLY, flushers.pop_front(), '0, ST_OK);
      if (step_results.size() > 0)
         step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i])
         awaited.push_back(step_results[i]);
   endfunction

   // request and register transfers feed the prediction
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         predict_results(op_type'(req_bus.opcode), req_bus.requester, req_bus.data_byte,
                         req_bus.rx_ready, req_bus.tx_ready, req_bus.modem_change,
                         req_bus.cts_level);
      if (!reset && csr_bus.valid && csr_bus.ready)
         cts_forced = csr_bus.cts_always;
   end

   // each result transfer against the oldest expectation
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{kind: kind_type'(rsp_bus.kind), target: rsp_bus.target,
                  value: rsp_bus.value, status: status_type'(rsp_bus.status),
                  last: rsp_bus.last};
         if (awaited.size() == 0) begin
            fail_count++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result: kind %0d target %02h value %02h status %0d last %0b",
                        seen.kind, seen.target, seen.value, seen.status, seen.last);
            end
         end else begin
            want = awaited.pop_front();
            if (seen.kind !== want.kind || seen.target !== want.target ||
                seen.value !== want.value || seen.status !== want.status ||
                seen.last !== want.last) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("mismatch: expected kind %0d target %02h value %02h status %0d last %0b",
                           want.kind, want.target, want.value, want.status, want.last);
                  $display("          got      kind %0d target %02h value %02h status %0d last %0b",
                           seen.kind, seen.target, seen.value, seen.status, seen.last);
               end
            end
         end
      end
   end

   // result side ready: random stalls, plus a counted hold-off on request
   always @(posedge clock) begin
      if (hold_tickets != hold_served) begin
         hold_served = hold_tickets;
         hold_left   = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (steady) begin
         rsp_bus.ready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // one request transfer; valid stays high so the next one can follow at once
   task automatic send_item(op_type op, id_t who, byte_t data,
                            logic rx, logic tx, logic mc, logic cts);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.requester    <= who;
      req_bus.data_byte    <= data;
      req_bus.rx_ready     <= rx;
      req_bus.tx_ready     <= tx;
      req_bus.modem_change <= mc;
      req_bus.cts_level    <= cts;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_random_item();
      int     roll;
      op_type op;
      roll = $urandom_range(0, 99);
      if (roll < 25)      op = OP_PUT;
      else if (roll < 45) op = OP_GET;
      else if (roll < 55) op = OP_FLUSH;
      else                op = OP_LINE;
      send_item(op, rnd8(), rnd8(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // stop offering, let every expected result arrive, then let
   // result-free transfers still in the pipe finish
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_cts_always(logic forced);
      csr_bus.valid      <= 1'b1;
      csr_bus.cts_always <= forced;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
   endtask

   // walk every operation and the corner cases from reset with a cts wire
   task automatic test_directed();
      write_cts_always(1'b0);
      send_item(OP_FLUSH, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);   // flush with nothing queued
      send_item(OP_GET,   8'hff, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);   // reader parks
      send_item(OP_LINE,  8'h00, 8'ha5, 1'b1, 1'b0, 1'b0, 1'b0);   // byte straight to reader
      send_item(OP_LINE,  8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);   // into receive fifo
      send_item(OP_LINE,  8'h00, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
      send_item(OP_GET,   8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);   // read from fifo
      send_item(OP_GET,   8'h02, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0);
      send_item(OP_PUT,   8'hff, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0);   // cts low, byte waits
      send_item(OP_PUT,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      send_item(OP_FLUSH, 8'h33, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);   // flush waiter parks
      send_item(OP_FLUSH, 8'h44, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);   // flush queue full
      send_item(OP_LINE,  8'h00, 8'h3c, 1'b0, 1'b0, 1'b1, 1'b1);   // cts rises, one byte out
      send_item(OP_LINE,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);   // cts was cleared by send
      send_item(OP_GET,   8'h77, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
      // reader reply, last byte out and flush release from one event
      send_item(OP_LINE,  8'h00, 8'h5a, 1'b1, 1'b1, 1'b1, 1'b1);
      send_item(OP_LINE,  8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);   // free and clear, fifo empty
      send_item(OP_PUT,   8'h12, 8'hc3, 1'b0, 1'b0, 1'b0, 1'b0);   // put sent at once
      send_item(OP_LINE,  8'hff, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0);   // empty event, fields ignored
      send_item(OP_LINE,  8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);   // cts falls
   endtask

   // result side held off while requests keep coming, block must stall its input
   task automatic test_backpressure();
      wait_drain();
      write_cts_always(1'b1);
      hold_len = 200;
      hold_tickets++;
      repeat (20) begin
         send_item(OP_PUT, rnd8(), rnd8(), 1'b0, 1'b0, 1'b0, 1'b0);
         send_item(OP_LINE, rnd8(), rnd8(), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
      end
   endtask

   // mixed traffic under both register settings, one phase without idling
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         wait_drain();
         write_cts_always(phase[0]);
         steady = (phase == 2);
         repeat (50) send_random_item();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= OP_PUT;
      req_bus.requester    <= '0;
      req_bus.data_byte    <= '0;
      req_bus.rx_ready     <= 1'b0;
      req_bus.tx_ready     <= 1'b0;
      req_bus.modem_change <= 1'b0;
      req_bus.cts_level    <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.cts_always   <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random_traffic();

      wait_drain();
      if (fail_count == 0 && awaited.size() == 0) begin
         $display("tb_uart_buffer_flow_control: done, clean");
      end else begin
         $display("tb_uart_buffer_flow_control: done, errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #20000000;
      $display("tb_uart_buffer_flow_control: done, errors");
      $finish;
   end

endmodule
